// ----- rtl/hsfc_pkg.sv -----
package hsfc_pkg;

   // direction codes
   localparam logic ACT_SGL_TO_HALF = 1'b0;
   localparam logic ACT_HALF_TO_SGL = 1'b1;

   // field widths
   localparam int unsigned SGL_W      = 32;
   localparam int unsigned HALF_W     = 16;
   localparam int unsigned SGL_EXP_W  = 8;
   localparam int unsigned SGL_FRAC_W = 23;
   localparam int unsigned HALF_EXP_W = 5;
   localparam int unsigned HALF_FRAC_W = 10;
   localparam int unsigned LZC_W      = 4;

   // bias difference between binary32 (127) and binary16 (15)
   localparam logic [SGL_EXP_W-1:0] EXP_GAP      = 8'd112;
   localparam logic [SGL_EXP_W-1:0] SGL_EXP_ONES = 8'hFF;
   // first single exponent that overflows half: gap + 31
   localparam logic [SGL_EXP_W-1:0] SGL_EXP_OVF  = 8'd143;
   // smallest single exponent sent down the half subnormal path: gap - 10
   localparam logic [SGL_EXP_W-1:0] SGL_EXP_TINY = 8'd102;
   // right shift for half subnormals is 126 - exponent (14 .. 24)
   localparam logic [SGL_EXP_W-1:0] SUB_SHIFT_BASE = 8'd126;

   localparam logic [HALF_EXP_W-1:0] HALF_EXP_ONES = 5'h1F;
   localparam logic [HALF_W-2:0] HALF_QNAN = 15'h7E00;
   localparam logic [HALF_W-2:0] HALF_INF  = 15'h7C00;

   // leading zeros of a nonzero 10-bit mantissa (0 .. 9)
   function automatic logic [LZC_W-1:0] lzc10(input logic [HALF_FRAC_W-1:0] v);
      logic [LZC_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < HALF_FRAC_W; i++) begin
         if (v[i]) begin
            cnt = LZC_W'(HALF_FRAC_W - 1 - i);
         end
      end
      return cnt;
   endfunction

endpackage

// ----- rtl/half_single_float_converter.sv -----
// Half/single float converter: binary32 <-> binary16 bit patterns.
// Each item passes the input register, then the result register, and
// rsp_valid rises with the result.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset (synchronous, active high) clears only the valid pipeline;
// the payload registers are not reset.
module half_single_float_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [hsfc_pkg::SGL_W-1:0]      req_single_bits,
   input  logic [hsfc_pkg::HALF_W-1:0]     req_half_bits,
   output logic                            rsp_valid,
   output logic [hsfc_pkg::HALF_W-1:0]     rsp_half_result,
   output logic [hsfc_pkg::SGL_W-1:0]      rsp_single_result
);

   // ---------------- input register ----------------
   logic                            valid_ff, valid_in;
   logic                            action_ff;
   logic [hsfc_pkg::SGL_W-1:0]      single_ff;
   logic [hsfc_pkg::HALF_W-1:0]     half_ff;

   // ---------------- result register ----------------
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [hsfc_pkg::HALF_W-1:0]     rsp_half_ff, rsp_half_in;
   logic [hsfc_pkg::SGL_W-1:0]      rsp_single_ff, rsp_single_in;

   // Nothing ever holds the pipe, so a new item is taken every cycle.
   assign busy     = 1'b0;
   assign valid_in = start && !busy;

   // ---------------- single -> half ----------------
   logic                                 s_sign;
   logic [hsfc_pkg::SGL_EXP_W-1:0]       s_exp;
   logic [hsfc_pkg::SGL_FRAC_W-1:0]      s_frac;
   logic [hsfc_pkg::SGL_EXP_W-1:0]       s_sub_shift;
   logic [hsfc_pkg::SGL_FRAC_W:0]        s_sub_mant;
   logic [hsfc_pkg::SGL_EXP_W-1:0]       s_norm_exp;
   logic [hsfc_pkg::HALF_W-2:0]          s_mag;

   assign s_sign = single_ff[hsfc_pkg::SGL_W-1];
   assign s_exp  = single_ff[hsfc_pkg::SGL_W-2:hsfc_pkg::SGL_FRAC_W];
   assign s_frac = single_ff[hsfc_pkg::SGL_FRAC_W-1:0];

   // Subnormal half: restore the hidden bit and shift it down (truncating).
   assign s_sub_shift = hsfc_pkg::SUB_SHIFT_BASE - s_exp;
   assign s_sub_mant  = {1'b1, s_frac} >> s_sub_shift[4:0];
   assign s_norm_exp  = s_exp - hsfc_pkg::EXP_GAP;

   always_comb begin
      if (s_exp == hsfc_pkg::SGL_EXP_ONES) begin
         // NaN collapses to the quiet NaN, infinity stays infinity
         s_mag = (s_frac != '0) ? hsfc_pkg::HALF_QNAN : hsfc_pkg::HALF_INF;
      end else if (s_exp >= hsfc_pkg::SGL_EXP_OVF) begin
         s_mag = hsfc_pkg::HALF_INF;
      end else if (s_exp < hsfc_pkg::SGL_EXP_TINY) begin
         s_mag = '0;                       // flushes to signed zero
      end else if (s_exp <= hsfc_pkg::EXP_GAP) begin
         s_mag = {5'd0, s_sub_mant[hsfc_pkg::HALF_FRAC_W-1:0]};
      end else begin
         s_mag = {s_norm_exp[hsfc_pkg::HALF_EXP_W-1:0],
                  s_frac[hsfc_pkg::SGL_FRAC_W-1:hsfc_pkg::SGL_FRAC_W-hsfc_pkg::HALF_FRAC_W]};
      end
   end

   // ---------------- half -> single ----------------
   logic                                 h_sign;
   logic [hsfc_pkg::HALF_EXP_W-1:0]      h_exp;
   logic [hsfc_pkg::HALF_FRAC_W-1:0]     h_frac;
   logic [hsfc_pkg::LZC_W-1:0]           h_lz;
   logic [hsfc_pkg::HALF_FRAC_W-1:0]     h_frac_shl;
   logic [hsfc_pkg::SGL_EXP_W-1:0]       h_out_exp;
   logic [hsfc_pkg::HALF_FRAC_W-1:0]     h_out_frac;

   assign h_sign = half_ff[hsfc_pkg::HALF_W-1];
   assign h_exp  = half_ff[hsfc_pkg::HALF_W-2:hsfc_pkg::HALF_FRAC_W];
   assign h_frac = half_ff[hsfc_pkg::HALF_FRAC_W-1:0];

   // Subnormal: move the leading one out into the hidden bit position.
   assign h_lz       = hsfc_pkg::lzc10(h_frac);
   assign h_frac_shl = h_frac << h_lz;

   always_comb begin
      if (h_exp == '0) begin
         if (h_frac == '0) begin
            h_out_exp  = '0;
            h_out_frac = '0;
         end else begin
            h_out_exp  = hsfc_pkg::EXP_GAP - {4'd0, h_lz};
            h_out_frac = {h_frac_shl[hsfc_pkg::HALF_FRAC_W-2:0], 1'b0};
         end
      end else if (h_exp == hsfc_pkg::HALF_EXP_ONES) begin
         // infinity or NaN, payload kept
         h_out_exp  = hsfc_pkg::SGL_EXP_ONES;
         h_out_frac = h_frac;
      end else begin
         h_out_exp  = {3'd0, h_exp} + hsfc_pkg::EXP_GAP;
         h_out_frac = h_frac;
      end
   end

   // ---------------- result select ----------------
   always_comb begin
      rsp_valid_in = valid_ff;
      if (action_ff == hsfc_pkg::ACT_HALF_TO_SGL) begin
         rsp_half_in   = '0;
         rsp_single_in = {h_sign, h_out_exp, h_out_frac, 13'd0};
      end else begin
         rsp_half_in   = {s_sign, s_mag};
         rsp_single_in = '0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (valid_in) begin
         action_ff <= req_action;
         single_ff <= req_single_bits;
         half_ff   <= req_half_bits;
      end
      if (rsp_valid_in) begin
         rsp_half_ff   <= rsp_half_in;
         rsp_single_ff <= rsp_single_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_half_result   = rsp_half_ff;
   assign rsp_single_result = rsp_single_ff;

`ifndef SYNTH
   // every result stems from an item taken at the input register
   a_rsp_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("result without a matching item");

   // the unused result field is zero
   a_s2h_single_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action, 2) == hsfc_pkg::ACT_SGL_TO_HALF)
         |-> rsp_single_result == '0)
      else $error("single_result not zero on single to half");

   a_h2s_half_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action, 2) == hsfc_pkg::ACT_HALF_TO_SGL)
         |-> rsp_half_result == '0)
      else $error("half_result not zero on half to single");

   // sign carries through single to half
   a_s2h_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action, 2) == hsfc_pkg::ACT_SGL_TO_HALF)
         |-> rsp_half_result[15] == $past(req_single_bits[31], 2))
      else $error("sign lost on single to half");

   // a normal half widens with its mantissa kept and the low bits zero
   a_h2s_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action, 2) == hsfc_pkg::ACT_HALF_TO_SGL
         && $past(req_half_bits[14:10], 2) != '0
         && $past(req_half_bits[14:10], 2) != hsfc_pkg::HALF_EXP_ONES)
         |-> (rsp_single_result[22:13] == $past(req_half_bits[9:0], 2)
              && rsp_single_result[12:0] == '0))
      else $error("normal half mantissa not preserved");
`endif

endmodule
